[rtl/core/bblt_pkg.sv]
package bblt_pkg;

	localparam int NUM_BANDS_DEF = 26;
	localparam int MAG_BITS_DEF  = 24;
	localparam int BAND_W        = 5;
	localparam int WIDTH_W       = 7;
	localparam int LEVEL_W       = 17;
	localparam int DIVISOR_W     = 8;
	localparam int SCALE_W       = 10;
	localparam int MAG_SCALE     = 1000;
	localparam int PEAK_RESET    = 6554;
	localparam int ONE_Q16       = 65536;
	localparam int LIMIT_CHANGE  = 131072;
	localparam int DIVISOR_RESET = 20;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 8;
	localparam int MID_DEPTH     = 2;
	localparam int OUT_DEPTH     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd1;

	typedef struct packed {
		logic [BAND_W-1:0]  band_index;
		logic [LEVEL_W-1:0] level;
		logic               last_band;
	} out_item_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MEAN,
		B_RATIO,
		B_STEP,
		B_EMIT
	} back_state_t;

	function automatic logic [WIDTH_W-1:0] bark_width(input logic [BAND_W-1:0] band);
		logic [WIDTH_W-1:0] w;
		case (band) inside
			[5'd0:5'd4]:   w = 7'd2;
			[5'd5:5'd8]:   w = 7'd3;
			[5'd9:5'd10]:  w = 7'd4;
			5'd11:         w = 7'd5;
			5'd12:         w = 7'd6;
			5'd13:         w = 7'd7;
			5'd14:         w = 7'd8;
			5'd15:         w = 7'd10;
			5'd16:         w = 7'd12;
			5'd17:         w = 7'd15;
			5'd18:         w = 7'd19;
			5'd19:         w = 7'd23;
			5'd20:         w = 7'd28;
			5'd21:         w = 7'd38;
			5'd22:         w = 7'd53;
			5'd23:         w = 7'd75;
			5'd24:         w = 7'd90;
			default:       w = 7'd94;
		endcase
		return w;
	endfunction

endpackage

[rtl/core/bblt_fifo.sv]
module bblt_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push & ~full;
	assign do_rd = pop & ~empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/core/bblt_div.sv]
module bblt_div #(
	parameter int DEN_W = 34,
	parameter int Q_W   = 34,
	localparam int CNT_W = $clog2(Q_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [Q_W-1:0]   bits_init,
	input  logic [DEN_W-1:0] den,
	input  logic [CNT_W-1:0] count,
	output logic             done,
	output logic [Q_W-1:0]   quot
);

	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   bits_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             qbit;

	// one quotient bit per cycle, numerator bits leave at the top
	assign trial = {rem_q, bits_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			bits_q <= bits_init;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			bits_q <= {bits_q[Q_W-2:0], qbit};
		end
	end

endmodule

[rtl/core/bblt_front.sv]
module bblt_front #(
	parameter int NUM_BANDS = bblt_pkg::NUM_BANDS_DEF,
	parameter int MAG_BITS  = bblt_pkg::MAG_BITS_DEF,
	localparam int TERM_W = MAG_BITS + bblt_pkg::SCALE_W,
	localparam int SUM_W  = TERM_W + bblt_pkg::WIDTH_W,
	localparam int ITEM_W = bblt_pkg::BAND_W + 1 + bblt_pkg::WIDTH_W + SUM_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enable,
	input  logic                push,
	output logic                full,
	input  logic [MAG_BITS-1:0] magnitude,
	input  logic                frame_start,
	input  logic                mid_full,
	output logic                mid_push,
	output logic [ITEM_W-1:0]   mid_data
);

	localparam int BAND_W  = bblt_pkg::BAND_W;
	localparam int WIDTH_W = bblt_pkg::WIDTH_W;

	logic [WIDTH_W-1:0] bin_q;
	logic [BAND_W-1:0]  band_q;
	logic [SUM_W-1:0]   sum_q;

	logic               accept;
	logic [WIDTH_W-1:0] base_bin;
	logic [BAND_W-1:0]  base_band;
	logic [SUM_W-1:0]   base_sum;
	logic [TERM_W-1:0]  term;
	logic [SUM_W-1:0]   sum_next;
	logic [WIDTH_W-1:0] bin_next;
	logic [WIDTH_W-1:0] width;
	logic               band_end;
	logic [BAND_W:0]    band_inc;
	logic               wrap;
	logic               last;

	assign full   = enable & mid_full;
	assign accept = push & enable & ~mid_full;

	always_comb begin
		base_bin  = frame_start ? '0 : bin_q;
		base_band = frame_start ? '0 : band_q;
		base_sum  = frame_start ? '0 : sum_q;
		term      = TERM_W'(magnitude) * TERM_W'(bblt_pkg::MAG_SCALE);
		sum_next  = base_sum + SUM_W'(term);
		bin_next  = base_bin + 1'b1;
		width     = bblt_pkg::bark_width(base_band);
		band_end  = (bin_next >= width);
		band_inc  = {1'b0, base_band} + 1'b1;
		wrap      = (band_inc >= (BAND_W + 1)'(NUM_BANDS));
		last      = (base_band == BAND_W'(NUM_BANDS - 1));
	end

	assign mid_push = accept & band_end;
	assign mid_data = {base_band, last, width, sum_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			band_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (band_end) begin
				bin_q  <= '0;
				sum_q  <= '0;
				band_q <= wrap ? '0 : band_inc[BAND_W-1:0];
			end else begin
				bin_q  <= bin_next;
				sum_q  <= sum_next;
				band_q <= base_band;
			end
		end
	end

endmodule

[rtl/core/bblt_back.sv]
module bblt_back #(
	parameter int NUM_BANDS = bblt_pkg::NUM_BANDS_DEF,
	parameter int MAG_BITS  = bblt_pkg::MAG_BITS_DEF,
	localparam int MEAN_W = MAG_BITS + bblt_pkg::SCALE_W,
	localparam int SUM_W  = MEAN_W + bblt_pkg::WIDTH_W,
	localparam int ITEM_W = bblt_pkg::BAND_W + 1 + bblt_pkg::WIDTH_W + SUM_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bblt_pkg::DIVISOR_W-1:0]   divisor,
	input  logic                             mid_empty,
	input  logic [ITEM_W-1:0]                mid_data,
	output logic                             mid_pop,
	input  logic                             out_full,
	output logic                             out_push,
	output bblt_pkg::out_item_t              out_data
);

	localparam int BAND_W  = bblt_pkg::BAND_W;
	localparam int WIDTH_W = bblt_pkg::WIDTH_W;
	localparam int LEVEL_W = bblt_pkg::LEVEL_W;
	localparam int CNT_W   = $clog2(MEAN_W + 1);
	localparam int BIDX_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

	bblt_pkg::back_state_t state_q, state_d;

	logic [BAND_W-1:0]  band_q;
	logic               last_q;
	logic               neg_q;
	logic [LEVEL_W-1:0] res_level_q;
	logic [MEAN_W-1:0]  peak_q [NUM_BANDS];
	logic [LEVEL_W-1:0] lvl_q  [NUM_BANDS];

	logic [BAND_W-1:0]  mid_band;
	logic               mid_last;
	logic [WIDTH_W-1:0] mid_width;
	logic [SUM_W-1:0]   mid_sum;

	logic               div_start;
	logic [MEAN_W-1:0]  div_rem;
	logic [MEAN_W-1:0]  div_bits;
	logic [MEAN_W-1:0]  div_den;
	logic [CNT_W-1:0]   div_count;
	logic               div_done;
	logic [MEAN_W-1:0]  div_quot;

	logic [BIDX_W-1:0]  bidx;
	logic [MEAN_W-1:0]  cur_peak;
	logic [LEVEL_W-1:0] cur_level;
	logic [MEAN_W-1:0]  peak_new;
	logic [LEVEL_W:0]   change;
	logic [LEVEL_W:0]   change_abs;
	logic               too_big;
	logic [bblt_pkg::DIVISOR_W-1:0] den_step;
	logic [LEVEL_W-1:0] level_step;
	logic [LEVEL_W-1:0] level_out;
	logic               job_load;
	logic               peak_we;
	logic               level_we;
	logic               level_set;
	logic               neg_load;

	assign mid_band  = mid_data[ITEM_W-1 -: BAND_W];
	assign mid_last  = mid_data[ITEM_W-1-BAND_W];
	assign mid_width = mid_data[SUM_W +: WIDTH_W];
	assign mid_sum   = mid_data[SUM_W-1:0];

	bblt_div #(
		.DEN_W(MEAN_W),
		.Q_W  (MEAN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.bits_init(div_bits),
		.den      (div_den),
		.count    (div_count),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		bidx       = band_q[BIDX_W-1:0];
		cur_peak   = peak_q[bidx];
		cur_level  = lvl_q[bidx];
		peak_new   = (div_quot > cur_peak) ? div_quot : cur_peak;
		change     = {1'b0, div_quot[LEVEL_W-1:0]} - {1'b0, cur_level};
		change_abs = change[LEVEL_W] ? (~change + 1'b1) : change;
		too_big    = (change_abs >= (LEVEL_W + 1)'(bblt_pkg::LIMIT_CHANGE));
		den_step   = (divisor == '0) ? bblt_pkg::DIVISOR_W'(1) : divisor;
		level_step = neg_q ? (cur_level - div_quot[LEVEL_W-1:0])
		                   : (cur_level + div_quot[LEVEL_W-1:0]);
	end

	always_comb begin
		state_d   = state_q;
		mid_pop   = 1'b0;
		out_push  = 1'b0;
		div_start = 1'b0;
		div_rem   = '0;
		div_bits  = '0;
		div_den   = '0;
		div_count = '0;
		job_load  = 1'b0;
		peak_we   = 1'b0;
		level_we  = 1'b0;
		level_set = 1'b0;
		level_out = cur_level;
		neg_load  = 1'b0;
		case (state_q)
			bblt_pkg::B_IDLE: begin
				if (!mid_empty) begin
					mid_pop   = 1'b1;
					job_load  = 1'b1;
					div_start = 1'b1;
					div_rem   = MEAN_W'(mid_sum >> MEAN_W);
					div_bits  = mid_sum[MEAN_W-1:0];
					div_den   = MEAN_W'(mid_width);
					div_count = CNT_W'(MEAN_W);
					state_d   = bblt_pkg::B_MEAN;
				end
			end
			bblt_pkg::B_MEAN: begin
				if (div_done) begin
					peak_we   = 1'b1;
					div_start = 1'b1;
					div_rem   = {1'b0, div_quot[MEAN_W-1:1]};
					div_bits  = {div_quot[0], {(MEAN_W - 1){1'b0}}};
					div_den   = peak_new;
					div_count = CNT_W'(LEVEL_W);
					state_d   = bblt_pkg::B_RATIO;
				end
			end
			bblt_pkg::B_RATIO: begin
				if (div_done) begin
					if (too_big) begin
						level_set = 1'b1;
						state_d   = bblt_pkg::B_EMIT;
					end else begin
						neg_load  = 1'b1;
						div_start = 1'b1;
						div_bits  = {change_abs[LEVEL_W-1:0], {(MEAN_W - LEVEL_W){1'b0}}};
						div_den   = MEAN_W'(den_step);
						div_count = CNT_W'(LEVEL_W);
						state_d   = bblt_pkg::B_STEP;
					end
				end
			end
			bblt_pkg::B_STEP: begin
				if (div_done) begin
					level_we  = 1'b1;
					level_set = 1'b1;
					level_out = level_step;
					state_d   = bblt_pkg::B_EMIT;
				end
			end
			bblt_pkg::B_EMIT: begin
				if (!out_full) begin
					out_push = 1'b1;
					state_d  = bblt_pkg::B_IDLE;
				end
			end
			default: state_d = bblt_pkg::B_IDLE;
		endcase
	end

	assign out_data = '{band_index: band_q, level: res_level_q, last_band: last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bblt_pkg::B_IDLE;
			for (int b = 0; b < NUM_BANDS; b++) begin
				peak_q[b] <= MEAN_W'(bblt_pkg::PEAK_RESET);
				lvl_q[b]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (peak_we) begin
				peak_q[bidx] <= peak_new;
			end
			if (level_we) begin
				lvl_q[bidx] <= level_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			band_q <= mid_band;
			last_q <= mid_last;
		end
		if (neg_load) begin
			neg_q <= change[LEVEL_W];
		end
		if (level_set) begin
			res_level_q <= level_out;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_push |-> !out_full)
		else $error("result pushed into a full output queue");
	assert property (@(posedge clk) disable iff (!arst_n) mid_pop |-> !mid_empty)
		else $error("band job taken from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == bblt_pkg::B_MEAN || state_q == bblt_pkg::B_RATIO ||
		              state_q == bblt_pkg::B_STEP))
		else $error("divider finished with no division pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bblt_pkg::B_RATIO && div_done) |-> (div_quot <= MEAN_W'(bblt_pkg::ONE_Q16)))
		else $error("band ratio above one");

endmodule

[rtl/core/bark_band_level_tracker_top.sv]
// Bark band level tracker. Bin magnitudes are pushed one per cycle while full is low (a frame
// is 513 bins, frame_start marks bin 0) and summed per band in the input stage, which accepts a
// bin every cycle while enabled and its two-entry band queue has room. Each completed band is
// finished by a back end built around one shared bit-serial divider, which computes in turn the
// mean, the mean/peak ratio and the level step; the back end finishes one band before it takes
// the next. Each band end yields one result item (band, level in Q1.16, last-of-frame mark)
// through a two-entry output queue. Registers: index 0 analysis_enable (reset 1), index 1
// smoothing_divisor (reset 20, 0 acts as 1); cfg_ready is always high and writes belong to
// idle periods.
module bark_band_level_tracker_top #(
	parameter int NUM_BANDS = bblt_pkg::NUM_BANDS_DEF,
	parameter int MAG_BITS  = bblt_pkg::MAG_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [MAG_BITS-1:0]             magnitude,
	input  logic                            frame_start,
	output logic                            empty,
	input  logic                            pop,
	output logic [bblt_pkg::BAND_W-1:0]     band_index,
	output logic [bblt_pkg::LEVEL_W-1:0]    level,
	output logic                            last_band,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bblt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bblt_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int MEAN_W = MAG_BITS + bblt_pkg::SCALE_W;
	localparam int SUM_W  = MEAN_W + bblt_pkg::WIDTH_W;
	localparam int ITEM_W = bblt_pkg::BAND_W + 1 + bblt_pkg::WIDTH_W + SUM_W;
	localparam int OUT_W  = $bits(bblt_pkg::out_item_t);

	logic                           enable_q;
	logic [bblt_pkg::DIVISOR_W-1:0] divisor_q;

	logic                mid_push;
	logic [ITEM_W-1:0]   mid_wdata;
	logic                mid_full;
	logic                mid_pop;
	logic [ITEM_W-1:0]   mid_rdata;
	logic                mid_empty;

	logic                out_push;
	bblt_pkg::out_item_t out_item;
	logic                out_full;
	logic [OUT_W-1:0]    out_rdata;
	bblt_pkg::out_item_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			divisor_q <= bblt_pkg::DIVISOR_W'(bblt_pkg::DIVISOR_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bblt_pkg::CFG_ENABLE:  enable_q  <= cfg_data[0];
				bblt_pkg::CFG_DIVISOR: divisor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bblt_front #(
		.NUM_BANDS(NUM_BANDS),
		.MAG_BITS (MAG_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (enable_q),
		.push       (push),
		.full       (full),
		.magnitude  (magnitude),
		.frame_start(frame_start),
		.mid_full   (mid_full),
		.mid_push   (mid_push),
		.mid_data   (mid_wdata)
	);

	bblt_fifo #(
		.W    (ITEM_W),
		.DEPTH(bblt_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	bblt_back #(
		.NUM_BANDS(NUM_BANDS),
		.MAG_BITS (MAG_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.divisor  (divisor_q),
		.mid_empty(mid_empty),
		.mid_data (mid_rdata),
		.mid_pop  (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (out_item)
	);

	bblt_fifo #(
		.W    (OUT_W),
		.DEPTH(bblt_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_item),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign head       = out_rdata;
	assign band_index = head.band_index;
	assign level      = head.level;
	assign last_band  = head.last_band;

endmodule
